// ===== hw/rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit-to-character map of the integer to
// ASCII digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_BITS_DEF  = 64;
  localparam int NUM_DIGITS      = 20;              // 20 decimal digits cover 64 bits
  localparam int DIG_BITS        = 4 * NUM_DIGITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NDIG_W          = $clog2(NUM_DIGITS + 1);
  localparam int IDX_W           = $clog2(NUM_DIGITS);

  // input opcodes
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_PTR  = 3'd4;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [1:0] {
    FMT_DEC,
    FMT_HEX_LO,
    FMT_HEX_UP,
    FMT_PTR
  } fmt_t;

  typedef struct packed {
    logic neg;
    fmt_t fmt;
  } ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UP_A : CH_LO_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts a value to its ASCII characters in signed or unsigned decimal,
// lower or upper hex, or pointer (0x) form, one character per output item.
// ----------------------------------------------------------------------------
// An item passes an input register, a sign/magnitude stage, ceil(VALUE_BITS/8)
// shift-and-add-3 stages of up to eight steps each (eight stages at 64 bits),
// and a digit-count stage before it reaches the character serializer. The
// serializer emits one character per cycle while the output is not stalled,
// 1 to 20 per item, and that sets the sustained rate: an item holds the
// serializer until its last character is out, while later items queue up in
// the conversion stages. Zero prints as a single '0' digit; opcodes 5 to 7
// act as unsigned decimal. A VALUE_BITS below 8 acts as 8 and one above 64
// acts as 64.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_code,
  output logic        out_last
);
  import itoa_pkg::*;

  localparam int VBITS = (VALUE_BITS < 8) ? 8 : ((VALUE_BITS > 64) ? 64 : VALUE_BITS);
  localparam int NSTAGE = (VBITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int LAST_STEPS = VBITS - STEPS_PER_STAGE * (NSTAGE - 1);

  // input register
  logic                  s0_v_r;
  logic [2:0]            s0_op_r;
  logic [VBITS-1:0]      s0_val_r;
  logic                  s0_rdy;

  // sign and magnitude
  logic                  s1_v_r;
  ctrl_t                 s1_ctrl_r;
  logic [VBITS-1:0]      s1_bin_r;
  logic                  s1_rdy;
  ctrl_t                 s1_ctrl_nxt;
  logic [VBITS-1:0]      s1_bin_nxt;

  // conversion chain
  logic                  d_v    [0:NSTAGE];
  logic                  d_rdy  [0:NSTAGE];
  ctrl_t                 d_ctrl [0:NSTAGE];
  logic [DIG_BITS-1:0]   d_bcd  [0:NSTAGE];
  logic [VBITS-1:0]      d_bin  [0:NSTAGE];

  // digit count
  logic                sc_v_r;
  ctrl_t               sc_ctrl_r;
  logic [DIG_BITS-1:0] sc_dig_r;
  logic [NDIG_W-1:0]   sc_ndig_r;
  logic [NDIG_W-1:0]   sc_ndig_nxt;
  logic                sc_rdy;
  logic                ser_rdy;

  assign s0_rdy   = !s0_v_r || s1_rdy;
  assign in_ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_rdy) begin
      s0_op_r  <= in_opcode;
      s0_val_r <= in_value[VBITS-1:0];
    end
  end

  always_comb begin
    s1_ctrl_nxt.neg = 1'b0;
    unique case (s0_op_r)
      OP_SDEC: begin
        s1_ctrl_nxt.fmt = FMT_DEC;
        s1_ctrl_nxt.neg = s0_val_r[VBITS-1];
      end
      OP_HEXL: s1_ctrl_nxt.fmt = FMT_HEX_LO;
      OP_HEXU: s1_ctrl_nxt.fmt = FMT_HEX_UP;
      OP_PTR:  s1_ctrl_nxt.fmt = FMT_PTR;
      default: s1_ctrl_nxt.fmt = FMT_DEC;  // unsigned decimal and unused codes
    endcase
    // most negative value negates to 2^(VBITS-1), exact as unsigned
    s1_bin_nxt = s1_ctrl_nxt.neg ? (~s0_val_r + VBITS'(1)) : s0_val_r;
  end

  assign s1_rdy = !s1_v_r || d_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_v_r && s1_rdy) begin
      s1_ctrl_r <= s1_ctrl_nxt;
      s1_bin_r  <= s1_bin_nxt;
    end
  end

  assign d_v[0]    = s1_v_r;
  assign d_ctrl[0] = s1_ctrl_r;
  assign d_bcd[0]  = '0;
  assign d_bin[0]  = s1_bin_r;

  for (genvar i = 0; i < NSTAGE; i++) begin : g_dab
    localparam int STEPS = (i == NSTAGE - 1) ? LAST_STEPS : STEPS_PER_STAGE;
    itoa_dabble_stage #(
      .VALUE_BITS (VBITS),
      .STEPS      (STEPS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d_v[i]),
      .in_ready  (d_rdy[i]),
      .in_ctrl   (d_ctrl[i]),
      .in_bcd    (d_bcd[i]),
      .in_bin    (d_bin[i]),
      .out_valid (d_v[i+1]),
      .out_ready (d_rdy[i+1]),
      .out_ctrl  (d_ctrl[i+1]),
      .out_bcd   (d_bcd[i+1]),
      .out_bin   (d_bin[i+1])
    );
  end

  // every input bit has been shifted out of the binary field by now
  assign sc_rdy        = !sc_v_r || ser_rdy;
  assign d_rdy[NSTAGE] = sc_rdy;

  always_comb begin
    sc_ndig_nxt = NDIG_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (d_bcd[NSTAGE][4*d +: 4] != 4'd0) begin
        sc_ndig_nxt = NDIG_W'(d + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else if (sc_rdy) begin
      sc_v_r <= d_v[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (d_v[NSTAGE] && sc_rdy) begin
      sc_ctrl_r <= d_ctrl[NSTAGE];
      sc_dig_r  <= d_bcd[NSTAGE];
      sc_ndig_r <= sc_ndig_nxt;
    end
  end

  itoa_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sc_v_r),
    .in_ready      (ser_rdy),
    .in_ctrl       (sc_ctrl_r),
    .in_digits     (sc_dig_r),
    .in_ndig       (sc_ndig_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

`ifndef ASSERT_OFF
  a_bin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    d_v[NSTAGE] |-> (d_bin[NSTAGE] == '0))
    else $error("binary field not fully shifted out");

  a_hold_s0: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_v_r && !s1_rdy) |=> (s0_v_r && $stable(s0_val_r) && $stable(s0_op_r)))
    else $error("stalled input item changed");

  a_hold_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (sc_v_r && !ser_rdy) |=> (sc_v_r && $stable(sc_dig_r) && $stable(sc_ndig_r)))
    else $error("stalled converted item changed");
`endif

endmodule

// ===== hw/rtl/itoa_dabble_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dabble_stage
// One register stage of the shift-and-add-3 converter. Hex items shift
// without the add, which leaves the plain nibbles in the digit field.
// ----------------------------------------------------------------------------
module itoa_dabble_stage #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
  parameter int STEPS      = itoa_pkg::STEPS_PER_STAGE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  itoa_pkg::ctrl_t               in_ctrl,
  input  logic [itoa_pkg::DIG_BITS-1:0] in_bcd,
  input  logic [VALUE_BITS-1:0]         in_bin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output itoa_pkg::ctrl_t               out_ctrl,
  output logic [itoa_pkg::DIG_BITS-1:0] out_bcd,
  output logic [VALUE_BITS-1:0]         out_bin
);
  import itoa_pkg::*;

  logic                           valid_r;
  ctrl_t                          ctrl_r;
  logic [DIG_BITS+VALUE_BITS-1:0] acc_r;
  logic [DIG_BITS+VALUE_BITS-1:0] acc_nxt;

  always_comb begin
    acc_nxt = {in_bcd, in_bin};
    for (int s = 0; s < STEPS; s++) begin
      if (in_ctrl.fmt == FMT_DEC) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          if (acc_nxt[VALUE_BITS+4*d +: 4] >= 4'd5) begin
            acc_nxt[VALUE_BITS+4*d +: 4] = acc_nxt[VALUE_BITS+4*d +: 4] + 4'd3;
          end
        end
      end
      acc_nxt = acc_nxt << 1;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_ctrl  = ctrl_r;
  assign out_bcd   = acc_r[DIG_BITS+VALUE_BITS-1:VALUE_BITS];
  assign out_bin   = acc_r[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctrl_r <= in_ctrl;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== hw/rtl/itoa_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_serializer
// Holds one converted item and emits its characters, prefix first, one per
// cycle while the receiver takes them, through a registered output.
// ----------------------------------------------------------------------------
module itoa_serializer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  itoa_pkg::ctrl_t               in_ctrl,
  input  logic [itoa_pkg::DIG_BITS-1:0] in_digits,
  input  logic [itoa_pkg::NDIG_W-1:0]   in_ndig,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char_code,
  output logic                          out_last
);
  import itoa_pkg::*;

  logic                busy_r;
  ctrl_t               ctrl_r;
  logic [DIG_BITS-1:0] dig_r;
  logic [NDIG_W-1:0]   ndig_r;
  logic [NDIG_W-1:0]   pos_r;
  logic                out_valid_r;
  logic [7:0]          char_r;
  logic                last_r;

  logic [1:0]        plen;
  logic [NDIG_W-1:0] total;
  logic [NDIG_W-1:0] idx_full;
  logic [3:0]        digit;
  logic [7:0]        cur_char;
  logic              is_last;
  logic              emit;

  always_comb begin
    if (ctrl_r.fmt == FMT_PTR) begin
      plen = 2'd2;
    end else if (ctrl_r.neg) begin
      plen = 2'd1;
    end else begin
      plen = 2'd0;
    end
    total    = ndig_r + NDIG_W'(plen);
    // digits go out most significant first
    idx_full = ndig_r - NDIG_W'(1) - (pos_r - NDIG_W'(plen));
    digit    = dig_r[4*idx_full[IDX_W-1:0] +: 4];
    if (pos_r < NDIG_W'(plen)) begin
      if (ctrl_r.fmt == FMT_PTR) begin
        cur_char = (pos_r == '0) ? CH_ZERO : CH_X;
      end else begin
        cur_char = CH_MINUS;
      end
    end else begin
      cur_char = digit_char(digit, ctrl_r.fmt == FMT_HEX_UP);
    end
    is_last = (pos_r == total - NDIG_W'(1));
  end

  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (emit && is_last);

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else if (emit) begin
        pos_r <= pos_r + NDIG_W'(1);
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= cur_char;
      last_r <= is_last;
    end
    if (in_valid && in_ready) begin
      ctrl_r <= in_ctrl;
      dig_r  <= in_digits;
      ndig_r <= in_ndig;
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pos_r < total))
    else $error("character position ran past the end of the item");

  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && busy_r) |-> (emit && is_last))
    else $error("new item loaded over one still being emitted");

  a_ndig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (ndig_r != '0))
    else $error("item held with no digits");
`endif

endmodule

// ===== tb/integer_to_ascii_digits_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb
// Drives values in every format through the converter and checks the emitted
// character stream, character by character, against locally computed text.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;
  import itoa_pkg::*;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 7;
  localparam int          RANDOM_ITEMS  = 470;
  localparam int          MAX_TEXT      = 20;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          QUIET_LIMIT   = 4000;
  localparam logic [2:0]  OP_SPARE_LO   = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_STEADY
  } rx_mode_t;

  // Holds the characters each accepted value should print, oldest first.
  class ascii_text_tracker;
    text_char_t expected_chars[$];
    int         errors = 0;

    function void push_char(logic [7:0] code);
      text_char_t c;
      c.code = code;
      c.last = 1'b0;
      expected_chars.push_back(c);
    endfunction

    function logic [7:0] digit_to_char(logic [3:0] d, bit upper);
      if (d < 4'd10) begin
        return CH_ZERO + 8'(d);
      end
      return (upper ? CH_UP_A : CH_LO_A) + 8'(d) - 8'd10;
    endfunction

    function void add_value(logic [2:0] op, logic [63:0] raw);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [7:0]  rev [MAX_TEXT];
      logic [3:0]  d;
      bit          upper;
      int          nd;
      mag   = raw;
      radix = 64'd10;
      upper = 1'b0;
      case (op) inside
        OP_HEXL, OP_PTR: radix = 64'd16;
        OP_HEXU: begin
          radix = 64'd16;
          upper = 1'b1;
        end
        default: ;
      endcase
      if (op == OP_SDEC && mag[63]) begin
        push_char(CH_MINUS);
        mag = -mag;
      end
      if (op == OP_PTR) begin
        push_char(CH_ZERO);
        push_char(CH_X);
      end
      nd = 0;
      do begin
        d       = 4'(mag % radix);
        rev[nd] = digit_to_char(d, upper);
        mag     = mag / radix;
        nd++;
      end while (mag != 64'd0 && nd < MAX_TEXT);
      for (int i = nd - 1; i >= 0; i--) begin
        push_char(rev[i]);
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    function void match_char(logic [7:0] code, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char item: expected none, actual code %h last %b",
                 $time, code, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $display("%0t: char_code mismatch: expected %h, actual %h", $time, want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode     = 3'd0;
  logic [63:0] in_value      = 64'd0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [7:0]  out_char_code;
  logic        out_last;

  ascii_text_tracker board = new();

  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_count   = 0;
  int       quiet      = 0;

  integer_to_ascii_digits DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Sender runs in bursts; a gap lowers valid only between items.
  task automatic offer_value(input logic [2:0] op, input logic [63:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.add_value(op, val);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] full;
    logic [63:0] small_mag;
    full      = {$urandom, $urandom};
    small_mag = 64'($urandom_range(0, 999));
    case ($urandom_range(0, 5))
      0:       return full;
      1:       return small_mag;
      2:       return full >> $urandom_range(0, 63);
      3:       return -small_mag;
      4:       return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      default: return ~(full >> $urandom_range(1, 63));
    endcase
  endfunction

  function automatic logic [2:0] pick_opcode();
    if ($urandom_range(0, 7) == 0) begin
      return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return 3'($urandom_range(OP_SDEC, OP_PTR));
  endfunction

  // Receiver stall pattern switches among four modes, each held for a random stretch.
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(RX_OPEN, RX_STEADY));
      rx_count <= $urandom_range(20, 120);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= $urandom_range(0, 3) != 0;
      RX_HEAVY: out_ready <= $urandom_range(0, 3) == 0;
      default:  out_ready <= (rx_count % 4) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.match_char(out_char_code, out_last);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog: no item moved for %0d cycles", $time, quiet);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // zero in every opcode, unused ones included
    for (int op = OP_SDEC; op <= OP_SPARE_HI; op++) begin
      offer_value(3'(op), 64'd0);
    end
    // all ones: -1 signed, maximum unsigned, full-width hex
    for (int op = OP_SDEC; op <= OP_PTR; op++) begin
      offer_value(3'(op), '1);
    end
    // most negative signed value and its neighbors
    offer_value(OP_SDEC, 64'h8000_0000_0000_0000);
    offer_value(OP_UDEC, 64'h8000_0000_0000_0000);
    offer_value(OP_PTR,  64'h8000_0000_0000_0000);
    offer_value(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
    offer_value(OP_UDEC, 64'd9999999999999999999);
    offer_value(OP_UDEC, 64'd10000000000000000000);
    offer_value(OP_UDEC, 64'd9);
    offer_value(OP_HEXL, 64'hDEAD_BEEF);
    offer_value(OP_HEXU, 64'hDEAD_BEEF);
    offer_value(OP_HEXU, 64'hFEDC_BA98_7654_3210);
    offer_value(OP_SDEC, 64'd1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offer_value(pick_opcode(), pick_value());
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
